// File: design/multi_buffer_trace_allocator_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the trace allocator
// Shared concurrent-assertion forms, clocked and held off during reset.
// ---------------------------------------------------------------------------
`ifndef MULTI_BUFFER_TRACE_ALLOCATOR_CORE_MACROS_SVH
`define MULTI_BUFFER_TRACE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define MBTA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mbta: same-cycle check failed");

// next-cycle implication
`define MBTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mbta: next-cycle check failed");

`endif

// File: design/mbta_pkg.sv
// ---------------------------------------------------------------------------
// Trace allocator package
// Fixed field widths, operation codes and controller types.
// ---------------------------------------------------------------------------
package mbta_pkg;

	// number of sub-buffers; buffer_index and release_index are sized for it
	localparam int unsigned NUM_BUFFERS = 4;

	localparam int unsigned SIZE_W   = 16;
	localparam int unsigned ENTRY_W  = 10;
	localparam int unsigned BIDX_W   = 2;
	localparam int unsigned HEAD_W   = 17;
	localparam int unsigned OFFSET_W = 16;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd4096;

	// operation codes carried in the mode field
	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_REPLY   = 2'd2,
		MODE_CONTROL = 2'd3
	} mbta_mode_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_COMMIT = 1'b1
	} mbta_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} mbta_cmd_t;

endpackage

// File: design/mbta_ctrl.sv
// ---------------------------------------------------------------------------
// Trace allocator controller
// Two-phase sequencer: capture the item, then commit its state changes.
// ---------------------------------------------------------------------------
module mbta_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output mbta_pkg::mbta_cmd_t cmd
);

	mbta_pkg::mbta_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbta_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		busy        = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			mbta_pkg::ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = mbta_pkg::ST_COMMIT;
				end
			end
			mbta_pkg::ST_COMMIT: begin
				busy       = 1'b1;
				cmd.commit = 1'b1;
				state_d    = mbta_pkg::ST_IDLE;
			end
			default: begin
				state_d = mbta_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/mbta_dp.sv
// ---------------------------------------------------------------------------
// Trace allocator datapath
// Buffer heads, empty flags, active buffer, interrupt flags and result regs.
// ---------------------------------------------------------------------------
`include "multi_buffer_trace_allocator_core_macros.svh"

module mbta_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mbta_pkg::mbta_cmd_t             cmd,
	input  logic                            cfg_write,
	input  logic [mbta_pkg::SIZE_W-1:0]     cfg_data,
	input  logic [1:0]                      mode,
	input  logic [mbta_pkg::ENTRY_W-1:0]    entry_bytes,
	input  logic [mbta_pkg::BIDX_W-1:0]     release_index,
	input  logic                            enable,
	output logic                            done,
	output logic                            granted,
	output logic [mbta_pkg::BIDX_W-1:0]     buffer_index,
	output logic [mbta_pkg::OFFSET_W-1:0]   entry_offset,
	output logic                            switched,
	output logic                            irq_fire,
	output logic                            reply_value
);

	localparam int unsigned NUM_BUFFERS = mbta_pkg::NUM_BUFFERS;
	localparam int unsigned IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam logic [NUM_BUFFERS-1:0] EMPTY_RESET = {{(NUM_BUFFERS-1){1'b1}}, 1'b0};

	// architectural state
	logic [mbta_pkg::SIZE_W-1:0] sub_bytes_q;
	logic [mbta_pkg::HEAD_W-1:0] head_q [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0]      empty_q;
	logic [IDX_W-1:0]            active_q;
	logic                        active_valid_q;
	logic                        irq_masked_q;
	logic                        irq_pending_q;

	// captured item
	mbta_pkg::mbta_mode_t         mode_s1;
	logic [mbta_pkg::ENTRY_W-1:0] entry_s1;
	logic [mbta_pkg::BIDX_W-1:0]  rel_s1;
	logic                         en_s1;
	logic [mbta_pkg::HEAD_W-1:0]  sum_s1;
	logic                         over_s1;

	// next-state values
	logic [mbta_pkg::HEAD_W-1:0] head_d [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0]      empty_d;
	logic [IDX_W-1:0]            active_d;
	logic                        active_valid_d;
	logic                        irq_masked_d;
	logic                        irq_pending_d;

	logic                          granted_d, switched_d, fire_d, reply_d;
	logic [mbta_pkg::BIDX_W-1:0]   bidx_d;
	logic [mbta_pkg::OFFSET_W-1:0] offset_d;

	logic             found;
	logic [IDX_W-1:0] next_idx;

	logic                          done_q, granted_q, switched_q, fire_q, reply_q;
	logic [mbta_pkg::BIDX_W-1:0]   bidx_q;
	logic [mbta_pkg::OFFSET_W-1:0] offset_q;

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_bytes_q <= mbta_pkg::SIZE_RESET;
		end else if (cfg_write) begin
			sub_bytes_q <= cfg_data;
		end
	end

	// capture stage: latch item, form the new head and the overflow test
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_s1  <= mbta_pkg::mbta_mode_t'(mode);
			entry_s1 <= entry_bytes;
			rel_s1   <= release_index;
			en_s1    <= enable;
			sum_s1   <= head_q[active_q] + mbta_pkg::HEAD_W'(entry_bytes);
			over_s1  <= (head_q[active_q] + mbta_pkg::HEAD_W'(entry_bytes))
				>= mbta_pkg::HEAD_W'(sub_bytes_q);
		end
	end

	// round-robin search for an empty buffer, starting after the active one
	always_comb begin
		logic [IDX_W:0] cand;
		found    = 1'b0;
		next_idx = '0;
		for (int n = 1; n <= NUM_BUFFERS; n++) begin
			cand = {1'b0, active_q} + (IDX_W+1)'(n);
			if (cand >= (IDX_W+1)'(NUM_BUFFERS)) begin
				cand = cand - (IDX_W+1)'(NUM_BUFFERS);
			end
			if (!found && empty_q[cand[IDX_W-1:0]]) begin
				found    = 1'b1;
				next_idx = cand[IDX_W-1:0];
			end
		end
	end

	// commit logic
	always_comb begin
		head_d         = head_q;
		empty_d        = empty_q;
		active_d       = active_q;
		active_valid_d = active_valid_q;
		irq_masked_d   = irq_masked_q;
		irq_pending_d  = irq_pending_q;
		granted_d      = 1'b0;
		switched_d     = 1'b0;
		fire_d         = 1'b0;
		reply_d        = 1'b0;
		bidx_d         = '0;
		offset_d       = '0;
		case (mode_s1)
			mbta_pkg::MODE_ALLOC: begin
				if (active_valid_q) begin
					if (over_s1) begin
						switched_d = 1'b1;
						if (found) begin
							active_d          = next_idx;
							empty_d[next_idx] = 1'b0;
							head_d[next_idx]  = mbta_pkg::HEAD_W'(entry_s1);
							granted_d         = 1'b1;
							bidx_d            = mbta_pkg::BIDX_W'(next_idx);
						end else begin
							active_valid_d = 1'b0;
						end
						// switch attempt: deliver now, or defer while masked
						if (!irq_masked_q) begin
							irq_masked_d = 1'b1;
							fire_d       = 1'b1;
						end else begin
							irq_pending_d = 1'b1;
						end
					end else begin
						granted_d        = 1'b1;
						bidx_d           = mbta_pkg::BIDX_W'(active_q);
						offset_d         = head_q[active_q][mbta_pkg::OFFSET_W-1:0];
						head_d[active_q] = sum_s1;
					end
				end
			end
			mbta_pkg::MODE_RELEASE: begin
				for (int i = 0; i < NUM_BUFFERS; i++) begin
					if (32'(rel_s1) == i) begin
						empty_d[i] = 1'b1;
					end
				end
			end
			mbta_pkg::MODE_REPLY: begin
				if (irq_pending_q) begin
					irq_pending_d = 1'b0;
					reply_d       = 1'b1;
				end else begin
					irq_masked_d = 1'b0;
				end
			end
			mbta_pkg::MODE_CONTROL: begin
				irq_masked_d = !en_s1;
			end
			default: begin
				granted_d = 1'b0;
			end
		endcase
	end

	// state update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				head_q[i] <= '0;
			end
			empty_q        <= EMPTY_RESET;
			active_q       <= '0;
			active_valid_q <= 1'b1;
			irq_masked_q   <= 1'b1;
			irq_pending_q  <= 1'b0;
		end else if (cmd.commit) begin
			head_q         <= head_d;
			empty_q        <= empty_d;
			active_q       <= active_d;
			active_valid_q <= active_valid_d;
			irq_masked_q   <= irq_masked_d;
			irq_pending_q  <= irq_pending_d;
		end
	end

	// result register: one-cycle strobe, fields zero when idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			granted_q  <= 1'b0;
			switched_q <= 1'b0;
			fire_q     <= 1'b0;
			reply_q    <= 1'b0;
			bidx_q     <= '0;
			offset_q   <= '0;
		end else begin
			done_q     <= cmd.commit;
			granted_q  <= cmd.commit & granted_d;
			switched_q <= cmd.commit & switched_d;
			fire_q     <= cmd.commit & fire_d;
			reply_q    <= cmd.commit & reply_d;
			bidx_q     <= cmd.commit ? bidx_d : '0;
			offset_q   <= cmd.commit ? offset_d : '0;
		end
	end

	assign done         = done_q;
	assign granted      = granted_q;
	assign buffer_index = bidx_q;
	assign entry_offset = offset_q;
	assign switched     = switched_q;
	assign irq_fire     = fire_q;
	assign reply_value  = reply_q;

	// checks
	`MBTA_ASSERT_NOW(a_quiet_idle, clk, arst_n, !done_q, !(granted_q || switched_q || fire_q || reply_q))
	`MBTA_ASSERT_NOW(a_fire_masks, clk, arst_n, fire_q, irq_masked_q)
	`MBTA_ASSERT_NEXT(a_exhaust_sticks, clk, arst_n, !active_valid_q, !active_valid_q)
	`MBTA_ASSERT_NOW(a_grant_active, clk, arst_n, granted_q, bidx_q == mbta_pkg::BIDX_W'(active_q))
	`MBTA_ASSERT_NOW(a_claim_clears, clk, arst_n, granted_q && switched_q, !empty_q[active_q])

endmodule

// File: design/multi_buffer_trace_allocator_core.sv
// ---------------------------------------------------------------------------
// Multi-buffer trace allocator
// Carves trace records from equal sub-buffers, switching round-robin to an
// empty buffer when the active one fills, with interrupt masking and reply.
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  item in  | start & !busy         | mode, entry_bytes, release_index, enable
//  result   | done (one cycle)      | granted, buffer_index, entry_offset,
//           |                       | switched, irq_fire, reply_value
//  config   | cfg_write             | cfg_data (sub-buffer size in bytes)
//
// The accept edge captures an item and forms the new head; ST_COMMIT then
// commits the buffer state and loads the result register.
// busy is high for the one commit cycle; done strobes the cycle after, while
// the next item may already be accepted. Results cannot be stalled.
// Reset is asynchronous and leaves every buffer but buffer zero empty.
// ---------------------------------------------------------------------------
module multi_buffer_trace_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_write,
	input  logic [mbta_pkg::SIZE_W-1:0]   cfg_data,
	input  logic [1:0]                    mode,
	input  logic [mbta_pkg::ENTRY_W-1:0]  entry_bytes,
	input  logic [mbta_pkg::BIDX_W-1:0]   release_index,
	input  logic                          enable,
	output logic                          done,
	output logic                          granted,
	output logic [mbta_pkg::BIDX_W-1:0]   buffer_index,
	output logic [mbta_pkg::OFFSET_W-1:0] entry_offset,
	output logic                          switched,
	output logic                          irq_fire,
	output logic                          reply_value
);

	mbta_pkg::mbta_cmd_t cmd;

	// sequencer
	mbta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// allocation state and results
	mbta_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.entry_bytes   (entry_bytes),
		.release_index (release_index),
		.enable        (enable),
		.done          (done),
		.granted       (granted),
		.buffer_index  (buffer_index),
		.entry_offset  (entry_offset),
		.switched      (switched),
		.irq_fire      (irq_fire),
		.reply_value   (reply_value)
	);

endmodule
